// ===== rtl/core/gtpu_encap_header_builder_core_defines.svh =====
// Assertion macros for the GTP-U encapsulation header builder.
`ifndef GTPU_ENCAP_HEADER_BUILDER_CORE_DEFINES_SVH
`define GTPU_ENCAP_HEADER_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GTPU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GTPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GTPU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define GTPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gtpu_pkg.sv =====
// Types and constants of the GTP-U encapsulation header builder.
`default_nettype none
package gtpu_pkg;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_IPV4 = 2'd0;
   localparam kind_type KIND_IPV6 = 2'd1;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_ROOM    = 2'd1,
      STAT_KIND    = 2'd2,
      STAT_LENGTH  = 2'd3
   } status_type;

   typedef logic csr_index_type;
   localparam csr_index_type CSR_SOURCE_ADDRESS = 1'b0;
   localparam csr_index_type CSR_TUNNEL_PORT    = 1'b1;

   // Header word positions, first word on the wire first
   typedef logic [3:0] word_idx_type;
   localparam word_idx_type W_VERSION  = 4'd0;
   localparam word_idx_type W_IDENT    = 4'd1;
   localparam word_idx_type W_TTL      = 4'd2;
   localparam word_idx_type W_SOURCE   = 4'd3;
   localparam word_idx_type W_DEST     = 4'd4;
   localparam word_idx_type W_PORTS    = 4'd5;
   localparam word_idx_type W_UDP_LEN  = 4'd6;
   localparam word_idx_type W_GTP      = 4'd7;
   localparam word_idx_type W_TEID     = 4'd8;

   localparam logic [15:0] HDR_BYTES      = 16'd36;
   localparam logic [15:0] ETH_BYTES      = 16'd14;
   localparam logic [15:0] FLEN_MAX       = 16'd65513;
   localparam logic [15:0] TOTAL_ADJUST   = 16'd22;
   localparam logic [15:0] UDP_ADJUST     = 16'd2;
   localparam logic [15:0] VER_TOS        = 16'h4500;
   localparam logic [15:0] IDENT          = 16'h0100;
   localparam logic [15:0] TTL_PROTO      = 16'h4011;
   localparam logic [15:0] GTP_FLAGS_TYPE = 16'h30FF;
   localparam logic [7:0]  V6_FIRST_OCTET = 8'h0A;
   localparam logic [15:0] PORT_RESET     = 16'd2152;

endpackage
`default_nettype wire

// ===== rtl/core/gtpu_encap_header_builder_core.sv =====
// Top level: builds the outer IPv4/UDP/GTP-U header, one 32-bit word per cycle
// while rsp_tready is high. Each request word (frame length, inner destination,
// headroom, inner kind) produces nine rsp words carrying the 36-byte outer
// header in network order, tlast on the ninth; a request that fails a check
// (headroom below 36, unknown kind, frame length below 14 or above 65513)
// produces one zero word with tlast and the status in tuser. The request is held
// in an input register, the header fields and checksum are computed in one pass
// into a result register, and a word counter on that register steps through the
// header. The next request is taken while the current header drains, so a steady
// stream runs back to back. csr writes must happen only while no packet is in
// flight.
`default_nettype none
`include "gtpu_encap_header_builder_core_defines.svh"
module gtpu_encap_header_builder_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] frame_length, [47:16] inner_destination, [63:48] headroom
   input  wire logic [63:0]            req_tdata,
   // [1:0] kind
   input  wire gtpu_pkg::kind_type     req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] header_word
   output logic [31:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   // [1:0] status, [2] rewrite_ethertype
   output logic [2:0]                  rsp_tuser,
   input  wire logic                   csr_write,
   input  wire gtpu_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_wdata
);
   import gtpu_pkg::*;

   // configuration
   logic [31:0] src_addr_ff, src_addr_in;
   logic [15:0] port_ff, port_in;

   // input stage
   logic        in_valid_ff, in_valid_in;
   kind_type    kind_ff;
   logic [15:0] flen_ff, room_ff;
   logic [31:0] dst_ff;

   // result stage
   logic         out_valid_ff, out_valid_in;
   word_idx_type word_idx_ff, word_idx_in;
   status_type   status_ff, status_in;
   logic         rewrite_ff, rewrite_in;
   logic [15:0]  total_ff, total_in;
   logic [15:0]  udp_len_ff, udp_len_in;
   logic [15:0]  gtp_len_ff, gtp_len_in;
   logic [31:0]  odst_ff, odst_in;
   logic [15:0]  csum_ff, csum_in;

   logic        out_last;
   logic        rsp_fire;
   logic        load_out;
   logic [18:0] sum_raw;
   logic [16:0] sum_fold1;
   logic [15:0] sum_fold2;

   always_comb begin
      src_addr_in = src_addr_ff;
      port_in     = port_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_ADDRESS: src_addr_in = csr_wdata;
            CSR_TUNNEL_PORT:    port_in     = csr_wdata[15:0];
            default:            src_addr_in = src_addr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff <= '0;
         port_ff     <= PORT_RESET;
      end else begin
         src_addr_ff <= src_addr_in;
         port_ff     <= port_in;
      end
   end

   assign out_last = (status_ff != STAT_OK) || (word_idx_ff == W_TEID);
   assign rsp_fire = out_valid_ff && rsp_tready;
   // move the held request forward when the result register is free or draining
   assign load_out = in_valid_ff && (!out_valid_ff || (rsp_fire && out_last));
   assign req_tready = !in_valid_ff || load_out;

   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (load_out ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser;
         flen_ff <= req_tdata[15:0];
         dst_ff  <= req_tdata[47:16];
         room_ff <= req_tdata[63:48];
      end
   end

   // header fields and checksum from the held request
   always_comb begin
      total_in   = flen_ff + TOTAL_ADJUST;
      udp_len_in = flen_ff + UDP_ADJUST;
      gtp_len_in = flen_ff - ETH_BYTES;
      rewrite_in = 1'b0;
      odst_in    = dst_ff;
      if (kind_ff == KIND_IPV6) begin
         odst_in    = {V6_FIRST_OCTET, dst_ff[23:0]};
         rewrite_in = 1'b1;
      end
      if (room_ff < HDR_BYTES) begin
         status_in = STAT_ROOM;
      end else if (kind_ff != KIND_IPV4 && kind_ff != KIND_IPV6) begin
         status_in = STAT_KIND;
      end else if (flen_ff > FLEN_MAX || flen_ff < ETH_BYTES) begin
         status_in = STAT_LENGTH;
      end else begin
         status_in = STAT_OK;
      end
      if (status_in != STAT_OK) begin
         rewrite_in = 1'b0;
      end
      sum_raw = {3'b0, VER_TOS} + {3'b0, total_in} + {3'b0, IDENT} + {3'b0, TTL_PROTO}
              + {3'b0, src_addr_ff[31:16]} + {3'b0, src_addr_ff[15:0]}
              + {3'b0, odst_in[31:16]} + {3'b0, odst_in[15:0]};
      sum_fold1 = {1'b0, sum_raw[15:0]} + {14'b0, sum_raw[18:16]};
      sum_fold2 = sum_fold1[15:0] + {15'b0, sum_fold1[16]};
      csum_in   = ~sum_fold2;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      word_idx_in  = word_idx_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         word_idx_in  = W_VERSION;
      end else if (rsp_fire) begin
         if (out_last) begin
            out_valid_in = 1'b0;
            word_idx_in  = W_VERSION;
         end else begin
            word_idx_in = word_idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         word_idx_ff  <= W_VERSION;
      end else begin
         out_valid_ff <= out_valid_in;
         word_idx_ff  <= word_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         status_ff  <= status_in;
         rewrite_ff <= rewrite_in;
         total_ff   <= total_in;
         udp_len_ff <= udp_len_in;
         gtp_len_ff <= gtp_len_in;
         odst_ff    <= odst_in;
         csum_ff    <= csum_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      if (status_ff == STAT_OK) begin
         case (word_idx_ff)
            W_VERSION: rsp_tdata = {VER_TOS, total_ff};
            W_IDENT:   rsp_tdata = {IDENT, 16'h0000};
            W_TTL:     rsp_tdata = {TTL_PROTO, csum_ff};
            W_SOURCE:  rsp_tdata = src_addr_ff;
            W_DEST:    rsp_tdata = odst_ff;
            W_PORTS:   rsp_tdata = {port_ff, port_ff};
            W_UDP_LEN: rsp_tdata = {udp_len_ff, 16'h0000};
            W_GTP:     rsp_tdata = {GTP_FLAGS_TYPE, gtp_len_ff};
            W_TEID:    rsp_tdata = '0;
            default:   rsp_tdata = '0;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last;
   assign rsp_tuser  = {rewrite_ff, status_ff};

   `GTPU_ASSERT_IMPLIES(a_err_single, clock, reset, rsp_tvalid && rsp_tuser[1:0] != STAT_OK, rsp_tlast && rsp_tdata == 32'h0, "rejected packet must be one zero word with tlast")
   `GTPU_ASSERT_IMPLIES(a_idx_range, clock, reset, out_valid_ff, word_idx_ff <= W_TEID, "word index past header end")
   `GTPU_ASSERT_NEXT(a_header_cont, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && word_idx_ff == $past(word_idx_ff) + 4'd1, "header words must follow without a gap")
   `GTPU_ASSERT_IMPLIES(a_rewrite_ok, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tuser[1:0] == STAT_OK, "ethertype rewrite flagged on a rejected packet")

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the GTP-U encapsulation header builder core.
module tb_top;
   import gtpu_pkg::*;

   // inner kinds that the block must reject
   localparam kind_type KIND_OTHER = 2'd2;
   localparam kind_type KIND_SPARE = 2'd3;
   localparam int WORDS_PER_HEADER = 9;
   localparam int DRAIN_CYCLES     = 8;
   localparam int HOLD_CYCLES      = 300;
   localparam int IDLE_LIMIT       = 4000;
   localparam int RANDOM_PACKETS   = 170;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
      status_type  status;
      logic        rewrite;
   } header_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // [15:0] frame_length, [47:16] inner_destination, [63:48] headroom
   logic [63:0]       req_tdata = '0;
   // [1:0] kind
   kind_type          req_tuser = KIND_IPV4;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [31:0] header_word
   logic [31:0]       rsp_tdata;
   logic              rsp_tlast;
   // [1:0] status, [2] rewrite_ethertype
   logic [2:0]        rsp_tuser;
   logic              csr_write = 1'b0;
   csr_index_type     csr_index = CSR_SOURCE_ADDRESS;
   logic [31:0]       csr_wdata = '0;

   // predictor copy of the registers
   logic [31:0] outer_source = 32'd0;
   logic [15:0] outer_port   = PORT_RESET;

   header_word_type expected_words[$];
   header_word_type want_word;

   int mismatches = 0;
   int words_checked = 0;
   int packets_sent = 0;
   int count_ok = 0;
   int count_v6 = 0;
   int count_room = 0;
   int count_kind = 0;
   int count_length = 0;
   int settings_used = 1;
   int burst_left = 0;

   logic hold_kick = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   pattern_left = 0;

   gtpu_encap_header_builder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // One's-complement sum over the five IPv4 header words, folded twice.
   function automatic logic [15:0] ipv4_checksum(input logic [31:0] w0, w1, w2, w3, w4);
      logic [19:0] sum;
      sum = w0[31:16] + w0[15:0] + w1[31:16] + w1[15:0] + w2[31:16] + w2[15:0]
          + w3[31:16] + w3[15:0] + w4[31:16] + w4[15:0];
      sum = {4'd0, sum[15:0]} + sum[19:16];
      sum = {4'd0, sum[15:0]} + sum[19:16];
      return ~sum[15:0];
   endfunction

   function automatic void push_reject(input status_type code);
      header_word_type hw;
      hw.word    = 32'd0;
      hw.last    = 1'b1;
      hw.status  = code;
      hw.rewrite = 1'b0;
      expected_words.push_back(hw);
   endfunction

   // Work out the outer header words for one accepted request.
   function automatic void predict_header(input kind_type kind, input logic [15:0] flen,
                                          input logic [31:0] dst, input logic [15:0] room);
      logic [31:0] hdr[WORDS_PER_HEADER];
      logic [31:0] outer_dst;
      logic [15:0] total_len, udp_len, gtp_len;
      logic        v6;
      header_word_type hw;
      packets_sent++;
      if (room < HDR_BYTES) begin
         push_reject(STAT_ROOM);
         count_room++;
      end else if (kind != KIND_IPV4 && kind != KIND_IPV6) begin
         push_reject(STAT_KIND);
         count_kind++;
      end else if (flen > FLEN_MAX || flen < ETH_BYTES) begin
         push_reject(STAT_LENGTH);
         count_length++;
      end else begin
         v6        = (kind == KIND_IPV6);
         outer_dst = v6 ? {V6_FIRST_OCTET, dst[23:0]} : dst;
         total_len = flen + TOTAL_ADJUST;
         udp_len   = flen + UDP_ADJUST;
         gtp_len   = flen - ETH_BYTES;
         hdr[0] = {VER_TOS, total_len};
         hdr[1] = {IDENT, 16'd0};
         hdr[2] = {TTL_PROTO, 16'd0};
         hdr[3] = outer_source;
         hdr[4] = outer_dst;
         hdr[2][15:0] = ipv4_checksum(hdr[0], hdr[1], hdr[2], hdr[3], hdr[4]);
         hdr[5] = {outer_port, outer_port};
         hdr[6] = {udp_len, 16'd0};
         hdr[7] = {GTP_FLAGS_TYPE, gtp_len};
         hdr[8] = 32'd0;
         for (int i = 0; i < WORDS_PER_HEADER; i++) begin
            hw.word    = hdr[i];
            hw.last    = (i == WORDS_PER_HEADER - 1);
            hw.status  = STAT_OK;
            hw.rewrite = v6;
            expected_words.push_back(hw);
         end
         count_ok++;
         if (v6) count_v6++;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // Compare each accepted word against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: word with nothing expected, expected none, actual %h last %b user %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want_word = expected_words.pop_front();
            check_field("header_word", want_word.word, rsp_tdata);
            check_field("word_last", want_word.last, rsp_tlast);
            check_field("status", want_word.status, rsp_tuser[1:0]);
            check_field("rewrite_ethertype", want_word.rewrite, rsp_tuser[2]);
         end
      end
   end

   // Receiver: random stall patterns, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen  <= hold_kick;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_mode   <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(16, 96);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // Watchdog: end the run when no word moves on either side for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_top: errors");
      $finish;
   end

   task automatic send_request(input kind_type kind, input logic [15:0] flen,
                               input logic [31:0] dst, input logic [15:0] room);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {room, dst, flen};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predict_header(kind, flen, dst, room);
      burst_left--;
   endtask

   // Mostly well-formed requests; a few rejected ones mixed in.
   task automatic send_random_request();
      kind_type    kind;
      logic [15:0] flen, room;
      int          pick;
      pick = $urandom_range(0, 99);
      kind = (pick < 45) ? KIND_IPV4 : (pick < 88) ? KIND_IPV6 :
             (pick < 94) ? KIND_OTHER : KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 60)      flen = 16'($urandom_range(14, 1500));
      else if (pick < 84) flen = 16'($urandom_range(14, 65513));
      else if (pick < 90) flen = 16'($urandom_range(65514, 65535));
      else if (pick < 95) flen = 16'($urandom_range(0, 13));
      else                flen = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 8)       room = 16'($urandom_range(0, 35));
      else if (pick < 25) room = 16'($urandom_range(36, 127));
      else                room = 16'($urandom_range(36, 65535));
      send_request(kind, flen, $urandom, room);
   endtask

   // Drop valid, wait for every expected word, then let the pipeline settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tunnel(input logic [31:0] src, input logic [15:0] port);
      csr_write <= 1'b1;
      csr_index <= CSR_SOURCE_ADDRESS;
      csr_wdata <= src;
      @(posedge clock);
      csr_index <= CSR_TUNNEL_PORT;
      csr_wdata <= {16'd0, port};
      @(posedge clock);
      csr_write <= 1'b0;
      outer_source = src;
      outer_port   = port;
      settings_used++;
   endtask

   task automatic test_reset_values();
      send_request(KIND_IPV4, 16'd100, 32'hC0A8_0001, HDR_BYTES);
      send_request(KIND_IPV6, 16'd1514, 32'h1234_5678, 16'd200);
      wait_drain();
   endtask

   task automatic test_checks_and_limits();
      send_request(KIND_IPV4, 16'd64, 32'h0A00_0001, 16'd0);
      send_request(KIND_IPV4, 16'd64, 32'h0A00_0001, 16'd35);
      // headroom is checked before kind and length
      send_request(KIND_OTHER, 16'd5, 32'h0A00_0001, 16'd35);
      send_request(KIND_OTHER, 16'd64, 32'h0A00_0002, 16'd64);
      // kind is checked before length
      send_request(KIND_SPARE, 16'd65535, 32'h0A00_0003, 16'd64);
      send_request(KIND_IPV4, 16'd65514, 32'h0A00_0004, 16'd64);
      send_request(KIND_IPV6, 16'd65535, 32'h0A00_0005, 16'd64);
      send_request(KIND_IPV4, 16'd13, 32'h0A00_0006, 16'd64);
      send_request(KIND_IPV6, 16'd0, 32'h0A00_0007, 16'd64);
      // zero-length GTP-U payload and largest total length
      send_request(KIND_IPV4, ETH_BYTES, 32'hFFFF_FFFF, 16'd65535);
      send_request(KIND_IPV6, FLEN_MAX, 32'hFFFF_FFFF, 16'd65535);
      send_request(KIND_IPV6, 16'd60, 32'h0000_0000, HDR_BYTES);
      send_request(KIND_IPV4, 16'd60, 32'h0000_0000, 16'd36);
      wait_drain();
   endtask

   task automatic test_register_extremes();
      write_tunnel(32'hFFFF_FFFF, 16'hFFFF);
      send_request(KIND_IPV4, 16'd1500, 32'hFFFF_FFFF, 16'd128);
      send_request(KIND_IPV6, 16'd9000, 32'h8000_0001, 16'd128);
      wait_drain();
      write_tunnel(32'd0, 16'd0);
      send_request(KIND_IPV4, 16'd14, 32'd0, 16'd36);
      send_request(KIND_IPV6, 16'd300, 32'h5555_AAAA, 16'd4096);
      wait_drain();
      write_tunnel($urandom, 16'($urandom_range(0, 65535)));
   endtask

   task automatic test_output_hold_off();
      hold_kick <= ~hold_kick;
      repeat (30) send_random_request();
      wait_drain();
   endtask

   task automatic test_random_stream();
      for (int n = 0; n < RANDOM_PACKETS; n++) begin
         if (n % 55 == 54) begin
            wait_drain();
            if ($urandom_range(0, 3) == 0)
               write_tunnel(($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0,
                            ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0);
            else
               write_tunnel($urandom, 16'($urandom_range(0, 65535)));
         end
         send_random_request();
      end
      wait_drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_checks_and_limits();
      test_register_extremes();
      test_output_hold_off();
      test_random_stream();
      $display("summary: %0d requests, %0d headers (%0d inner IPv6), rejected %0d headroom,",
               packets_sent, count_ok, count_v6, count_room);
      $display("summary: %0d kind, %0d length; %0d words checked over %0d tunnel settings",
               count_kind, count_length, words_checked, settings_used);
      if (mismatches == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
